/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("%m: invariant violated");

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
    else $error("%m: implication violated");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
    else $error("%m: next-cycle implication violated");

`else

`define ASSERT_ALWAYS(label, clk, rst_n, expr)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/mjdc_pkg.sv */
// ----------------------------------------------------------------------------
// mjdc_pkg
// Types, constants and tables for the MJD to civil date and GPS time pipeline.
// ----------------------------------------------------------------------------
package mjdc_pkg;

  // Pipeline depths
  localparam int unsigned DATE_STAGES = 11;
  localparam int unsigned TIME_STAGES = 5;
  localparam int unsigned TIME_PAD    = DATE_STAGES - TIME_STAGES + 1;
  localparam int unsigned OUT_LATENCY = DATE_STAGES + 1;

  // Range limits
  localparam logic [16:0] GPS_EPOCH_MJD   = 17'd44244;
  localparam logic [16:0] SECONDS_PER_DAY = 17'd86400;

  // Offsets of the scaled Julian-day steps
  localparam logic [21:0] A_OFFSET   = 22'd2131139;  // 4*(mjd+2400001) - 7468865
  localparam logic [19:0] C_OFFSET   = 20'd679007;   // 2400002 - 1720995
  localparam logic [23:0] Y_OFFSET   = 24'd2442;
  localparam logic [20:0] DOY_OFFSET = 21'd678576;

  // Reciprocal constants: floor(x / D) == (x * ceil(2^S / D)) >> S over the used range
  localparam int unsigned     A_SHIFT = 40;
  localparam longint unsigned A_DIV   = 146097;
  localparam logic [22:0]     A_RECIP = 23'(((64'd1 << A_SHIFT) + A_DIV - 64'd1) / A_DIV);

  localparam int unsigned     Y_SHIFT = 37;
  localparam longint unsigned Y_DIV   = 7305;
  localparam logic [24:0]     Y_RECIP = 25'(((64'd1 << Y_SHIFT) + Y_DIV - 64'd1) / Y_DIV);

  localparam int unsigned     M_SHIFT = 42;
  localparam longint unsigned M_DIV   = 306001;
  localparam logic [23:0]     M_RECIP = 24'(((64'd1 << M_SHIFT) + M_DIV - 64'd1) / M_DIV);

  localparam int unsigned     C_SHIFT = 19;
  localparam longint unsigned C_DIV   = 100;
  localparam logic [12:0]     C_RECIP = 13'(((64'd1 << C_SHIFT) + C_DIV - 64'd1) / C_DIV);

  localparam int unsigned     H_SHIFT = 29;
  localparam longint unsigned H_DIV   = 3600;
  localparam logic [17:0]     H_RECIP = 18'(((64'd1 << H_SHIFT) + H_DIV - 64'd1) / H_DIV);

  localparam int unsigned     N_SHIFT = 18;
  localparam longint unsigned N_DIV   = 60;
  localparam logic [12:0]     N_RECIP = 13'(((64'd1 << N_SHIFT) + N_DIV - 64'd1) / N_DIV);

  localparam int unsigned     W_SHIFT = 20;
  localparam longint unsigned W_DIV   = 7;
  localparam logic [17:0]     W_RECIP = 18'(((64'd1 << W_SHIFT) + W_DIV - 64'd1) / W_DIV);

  typedef struct packed {
    logic [16:0] day_number;
    logic [16:0] second_of_day;
  } mjdc_in_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  day_of_year;
  } mjdc_date_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [13:0] gps_week;
    logic [2:0]  week_day;
    logic [19:0] seconds_of_week;
  } mjdc_time_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [8:0]  day_of_year;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [13:0] gps_week;
    logic [2:0]  week_day;
    logic [19:0] seconds_of_week;
    logic        input_valid;
  } mjdc_out_t;

  // floor(30.6001 * m)
  function automatic logic [8:0] month_span(logic [3:0] m);
    logic [8:0] res;
    case (m)
      4'd0:    res = 9'd0;
      4'd1:    res = 9'd30;
      4'd2:    res = 9'd61;
      4'd3:    res = 9'd91;
      4'd4:    res = 9'd122;
      4'd5:    res = 9'd153;
      4'd6:    res = 9'd183;
      4'd7:    res = 9'd214;
      4'd8:    res = 9'd244;
      4'd9:    res = 9'd275;
      4'd10:   res = 9'd306;
      4'd11:   res = 9'd336;
      4'd12:   res = 9'd367;
      4'd13:   res = 9'd397;
      4'd14:   res = 9'd428;
      4'd15:   res = 9'd459;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

  // week_day * 86400
  function automatic logic [19:0] week_day_base(logic [2:0] wd);
    logic [19:0] res;
    case (wd)
      3'd0:    res = 20'd0;
      3'd1:    res = 20'd86400;
      3'd2:    res = 20'd172800;
      3'd3:    res = 20'd259200;
      3'd4:    res = 20'd345600;
      3'd5:    res = 20'd432000;
      3'd6:    res = 20'd518400;
      default: res = 20'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/mjdc_date_pipe.sv */
// ----------------------------------------------------------------------------
// mjdc_date_pipe
// Julian-day decomposition of an MJD into Gregorian year, month, day and
// day of year, as an eleven-stage pipeline.
// ----------------------------------------------------------------------------
module mjdc_date_pipe (
  input  logic                 clk,
  input  logic [16:0]          day_number,
  output mjdc_pkg::mjdc_date_t date
);

  logic [16:0] mjd_r [mjdc_pkg::DATE_STAGES-1];

  logic [21:0] xa_r;
  logic [44:0] pa_r;
  logic [4:0]  a_val;
  logic [19:0] c_nxt, c_r, c4_r, c5_r;
  logic [23:0] xy_nxt, xy_r;
  logic [48:0] py_r;
  logic [11:0] y_val;
  logic [22:0] ys_full;
  logic [8:0]  rem_nxt;
  logic [11:0] y6_r, y7_r, y8_r;
  logic [8:0]  rem6_r, rem7_r, rem8_r;
  logic [22:0] xm_r;
  logic [46:0] pm_r;
  logic [3:0]  m_val;
  logic [3:0]  month_nxt, month9_r, month10_r;
  logic [4:0]  day_nxt, day9_r, day10_r;
  logic [11:0] year_nxt, year9_r, year10_r;
  logic [11:0] yy;
  logic [22:0] ys10_full;
  logic [24:0] pc_r;
  logic [19:0] ys10_r;
  logic [5:0]  cent;
  logic [20:0] doy_full;
  mjdc_pkg::mjdc_date_t date_r;

  always_comb begin
    a_val     = pa_r[mjdc_pkg::A_SHIFT +: 5];
    c_nxt     = 20'(mjd_r[1]) + mjdc_pkg::C_OFFSET + 20'(a_val) - 20'(a_val[4:2]);
    xy_nxt    = {c_r, 4'b0000} + {2'b00, c_r, 2'b00} - mjdc_pkg::Y_OFFSET;
    y_val     = py_r[mjdc_pkg::Y_SHIFT +: 12];
    ys_full   = 23'(y_val) * 23'd1461;
    rem_nxt   = 9'(c5_r - ys_full[21:2]);
    m_val     = pm_r[mjdc_pkg::M_SHIFT +: 4];
    day_nxt   = 5'(rem8_r - mjdc_pkg::month_span(m_val));
    month_nxt = (m_val > 4'd13) ? m_val - 4'd13 : m_val - 4'd1;
    year_nxt  = y8_r + ((month_nxt <= 4'd2) ? 12'd1 : 12'd0);
    yy        = year9_r - 12'd1;
    ys10_full = 23'(yy) * 23'd1461;
    cent      = pc_r[mjdc_pkg::C_SHIFT +: 6];
    doy_full  = 21'(mjd_r[9]) + mjdc_pkg::DOY_OFFSET + 21'(cent) - 21'(cent[5:2])
                - 21'(ys10_r);
  end

  always_ff @(posedge clk) begin
    mjd_r[0] <= day_number;
    for (int i = 1; i < int'(mjdc_pkg::DATE_STAGES) - 1; i++) begin
      mjd_r[i] <= mjd_r[i-1];
    end
    // stage 1
    xa_r      <= {3'b000, day_number, 2'b00} + mjdc_pkg::A_OFFSET;
    // stage 2
    pa_r      <= 45'(xa_r) * 45'(mjdc_pkg::A_RECIP);
    // stage 3
    c_r       <= c_nxt;
    // stage 4
    xy_r      <= xy_nxt;
    c4_r      <= c_r;
    // stage 5
    py_r      <= 49'(xy_r) * 49'(mjdc_pkg::Y_RECIP);
    c5_r      <= c4_r;
    // stage 6
    y6_r      <= y_val;
    rem6_r    <= rem_nxt;
    // stage 7
    xm_r      <= 23'(rem6_r) * 23'd10000;
    y7_r      <= y6_r;
    rem7_r    <= rem6_r;
    // stage 8
    pm_r      <= 47'(xm_r) * 47'(mjdc_pkg::M_RECIP);
    y8_r      <= y7_r;
    rem8_r    <= rem7_r;
    // stage 9
    year9_r   <= year_nxt;
    month9_r  <= month_nxt;
    day9_r    <= day_nxt;
    // stage 10
    pc_r      <= 25'(yy) * 25'(mjdc_pkg::C_RECIP);
    ys10_r    <= ys10_full[21:2];
    year10_r  <= year9_r;
    month10_r <= month9_r;
    day10_r   <= day9_r;
    // stage 11
    date_r.year        <= year10_r;
    date_r.month       <= month10_r;
    date_r.day         <= day10_r;
    date_r.day_of_year <= doy_full[8:0];
  end

  assign date = date_r;

endmodule

/* rtl/mjdc_time_pipe.sv */
// ----------------------------------------------------------------------------
// mjdc_time_pipe
// Time of day, GPS week, week day and seconds of week, five stages plus a
// delay line that lines the result up with the date pipeline.
// ----------------------------------------------------------------------------
module mjdc_time_pipe (
  input  logic                 clk,
  input  logic [16:0]          day_number,
  input  logic [16:0]          second_of_day,
  output mjdc_pkg::mjdc_time_t tod
);

  logic [16:0] days_r, days2_r;
  logic [16:0] sod1_r, sod2_r, sod3_r, sod4_r;
  logic [34:0] ph_r, pw_r;
  logic [5:0]  hour_val;
  logic [14:0] wk_val;
  logic [11:0] remh_nxt, remh3_r, remh4_r;
  logic [17:0] wd_full;
  logic [5:0]  hour3_r, hour4_r;
  logic [13:0] wk3_r, wk4_r;
  logic [2:0]  wd3_r, wd4_r;
  logic [24:0] pn_r;
  logic [19:0] sowb_r;
  logic [5:0]  minute_val;
  logic [11:0] sec_full;
  mjdc_pkg::mjdc_time_t tod_nxt;
  mjdc_pkg::mjdc_time_t pad_r [mjdc_pkg::TIME_PAD];

  always_comb begin
    hour_val   = ph_r[mjdc_pkg::H_SHIFT +: 6];
    wk_val     = pw_r[mjdc_pkg::W_SHIFT +: 15];
    remh_nxt   = 12'(sod2_r - 17'(hour_val) * 17'd3600);
    wd_full    = 18'(days2_r) - 18'(wk_val) * 18'd7;
    minute_val = pn_r[mjdc_pkg::N_SHIFT +: 6];
    sec_full   = remh4_r - 12'(minute_val) * 12'd60;

    tod_nxt.hour            = hour4_r[4:0];
    tod_nxt.minute          = minute_val;
    tod_nxt.second          = sec_full[5:0];
    tod_nxt.gps_week        = wk4_r;
    tod_nxt.week_day        = wd4_r;
    tod_nxt.seconds_of_week = sowb_r + 20'(sod4_r);
  end

  always_ff @(posedge clk) begin
    // stage 1
    days_r  <= day_number - mjdc_pkg::GPS_EPOCH_MJD;
    sod1_r  <= second_of_day;
    // stage 2
    ph_r    <= 35'(sod1_r) * 35'(mjdc_pkg::H_RECIP);
    pw_r    <= 35'(days_r) * 35'(mjdc_pkg::W_RECIP);
    sod2_r  <= sod1_r;
    days2_r <= days_r;
    // stage 3
    hour3_r <= hour_val;
    wk3_r   <= wk_val[13:0];
    wd3_r   <= wd_full[2:0];
    remh3_r <= remh_nxt;
    sod3_r  <= sod2_r;
    // stage 4
    pn_r    <= 25'(remh3_r) * 25'(mjdc_pkg::N_RECIP);
    sowb_r  <= mjdc_pkg::week_day_base(wd3_r);
    hour4_r <= hour3_r;
    wk4_r   <= wk3_r;
    wd4_r   <= wd3_r;
    remh4_r <= remh3_r;
    sod4_r  <= sod3_r;
    // stage 5 and delay line
    pad_r[0] <= tod_nxt;
    for (int i = 1; i < int'(mjdc_pkg::TIME_PAD); i++) begin
      pad_r[i] <= pad_r[i-1];
    end
  end

  assign tod = pad_r[mjdc_pkg::TIME_PAD-1];

endmodule

/* rtl/mjd_to_civil_and_gps_time.sv */
// ----------------------------------------------------------------------------
// mjd_to_civil_and_gps_time
// Converts an MJD and second of day into Gregorian date, day of year, time
// of day, GPS week, week day and GPS seconds of week.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  input    | start, busy        | in_data  (mjdc_pkg::mjdc_in_t)
//  result   | out_valid (strobe) | out_data (mjdc_pkg::mjdc_out_t)
//
// One beat per cycle; busy stays low. Each beat gives one result, registered
// through the eleven-stage date pipeline and then the output register; the
// reciprocal multipliers of the Julian-day steps set the depth.
// rst_n clears the valid pipeline; data registers are not reset.
// The receiver cannot stall, so the pipeline advances every cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mjd_to_civil_and_gps_time (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  mjdc_pkg::mjdc_in_t  in_data,
  output logic                out_valid,
  output mjdc_pkg::mjdc_out_t out_data
);

  logic                 in_beat;
  logic                 in_ok;
  logic                 vld_r [mjdc_pkg::DATE_STAGES];
  logic                 ok_r  [mjdc_pkg::DATE_STAGES];
  mjdc_pkg::mjdc_date_t date;
  mjdc_pkg::mjdc_time_t tod;
  mjdc_pkg::mjdc_out_t  res_nxt;
  mjdc_pkg::mjdc_out_t  out_data_r;
  logic                 out_valid_r;

  assign busy    = 1'b0;
  assign in_beat = start & ~busy;
  assign in_ok   = (in_data.day_number >= mjdc_pkg::GPS_EPOCH_MJD) &&
                   (in_data.second_of_day < mjdc_pkg::SECONDS_PER_DAY);

  mjdc_date_pipe u_date (
    .clk        (clk),
    .day_number (in_data.day_number),
    .date       (date)
  );

  mjdc_time_pipe u_time (
    .clk           (clk),
    .day_number    (in_data.day_number),
    .second_of_day (in_data.second_of_day),
    .tod           (tod)
  );

  always_comb begin
    res_nxt = '0;
    if (ok_r[mjdc_pkg::DATE_STAGES-1]) begin
      res_nxt.year            = date.year;
      res_nxt.month           = date.month;
      res_nxt.day             = date.day;
      res_nxt.day_of_year     = date.day_of_year;
      res_nxt.hour            = tod.hour;
      res_nxt.minute          = tod.minute;
      res_nxt.second          = tod.second;
      res_nxt.gps_week        = tod.gps_week;
      res_nxt.week_day        = tod.week_day;
      res_nxt.seconds_of_week = tod.seconds_of_week;
      res_nxt.input_valid     = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(mjdc_pkg::DATE_STAGES); i++) begin
        vld_r[i] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      vld_r[0] <= in_beat;
      for (int i = 1; i < int'(mjdc_pkg::DATE_STAGES); i++) begin
        vld_r[i] <= vld_r[i-1];
      end
      out_valid_r <= vld_r[mjdc_pkg::DATE_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    ok_r[0] <= in_ok;
    for (int i = 1; i < int'(mjdc_pkg::DATE_STAGES); i++) begin
      ok_r[i] <= ok_r[i-1];
    end
    out_data_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_IMPLIES(a_beat_gives_result, clk, rst_n, start && !busy, ##(mjdc_pkg::OUT_LATENCY) out_valid)
  `ASSERT_IMPLIES(a_result_has_beat, clk, rst_n, out_valid, $past(start && !busy, mjdc_pkg::OUT_LATENCY))
  `ASSERT_ALWAYS(a_rejected_zero, clk, rst_n, !(out_valid && !out_data.input_valid) || (out_data.year == 12'd0 && out_data.gps_week == 14'd0 && out_data.seconds_of_week == 20'd0))
  `ASSERT_ALWAYS(a_valid_ranges, clk, rst_n, !(out_valid && out_data.input_valid) || (out_data.month >= 4'd1 && out_data.month <= 4'd12 && out_data.day >= 5'd1 && out_data.week_day <= 3'd6))

endmodule

/* tb/tb_mjd_to_civil_and_gps_time.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_mjd_to_civil_and_gps_time
// Drives directed and then random bursts of MJD and second-of-day beats
// into the converter, predicts each Gregorian date, day of year, time of
// day and GPS week result in exact integer arithmetic, and checks every
// strobed result in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_mjd_to_civil_and_gps_time;
  import mjdc_pkg::*;

  localparam int RANDOM_ITEMS   = 1700;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 2 * OUT_LATENCY;
  localparam int MAX_REPORTS    = 10;

  localparam longint unsigned JD_BIAS       = 2400001;
  localparam longint unsigned GREG_OFFSET   = 7468865;
  localparam longint unsigned DAYS_PER_400Y = 146097;
  localparam longint unsigned JULIAN_BASE   = 1720995;
  localparam longint unsigned YEAR_OFFSET   = 2442;
  localparam longint unsigned DAYS_PER_20Y  = 7305;
  localparam longint unsigned MONTH_SCALED  = 306001;
  localparam longint unsigned MONTH_SCALE   = 10000;
  localparam longint unsigned MJD_TO_JDAY   = 679006;

  class conversion_board;
    mjdc_out_t awaited_q[$];
    int        errors;

    static function longint unsigned quarter_years(longint unsigned n);
      return (n * 1461) / 4;
    endfunction

    static function longint unsigned month_days(longint unsigned n);
      return (n * MONTH_SCALED) / MONTH_SCALE;
    endfunction

    static function mjdc_out_t predict_civil_time(mjdc_in_t beat);
      longint unsigned mjd, sod, jd, a, b, c, y, rem, m, mon, yr, py, cent, jan1, days, wd;
      mjdc_out_t r;
      r   = '0;
      mjd = beat.day_number;
      sod = beat.second_of_day;
      if (mjd < GPS_EPOCH_MJD || sod >= SECONDS_PER_DAY) return r;
      jd   = mjd + JD_BIAS;
      a    = (jd * 4 - GREG_OFFSET) / DAYS_PER_400Y;
      b    = jd + 1 + a - a / 4;
      c    = b - JULIAN_BASE;
      y    = (c * 20 - YEAR_OFFSET) / DAYS_PER_20Y;
      rem  = c - quarter_years(y);
      m    = (rem * MONTH_SCALE) / MONTH_SCALED;
      mon  = (m > 13) ? m - 13 : m - 1;
      yr   = (mon <= 2) ? y + 1 : y;
      py   = yr - 1;
      cent = py / 100;
      jan1 = quarter_years(py) + month_days(14) + 3 + cent / 4 - MJD_TO_JDAY - cent;
      days = mjd - GPS_EPOCH_MJD;
      wd   = days % 7;
      r.year            = 12'(yr);
      r.month           = 4'(mon);
      r.day             = 5'(rem - month_days(m));
      r.day_of_year     = 9'(mjd - jan1 + 1);
      r.hour            = 5'(sod / 3600);
      r.minute          = 6'((sod % 3600) / 60);
      r.second          = 6'(sod % 60);
      r.gps_week        = 14'(days / 7);
      r.week_day        = 3'(wd);
      r.seconds_of_week = 20'(wd * SECONDS_PER_DAY + sod);
      r.input_valid     = 1'b1;
      return r;
    endfunction

    function void note_input(mjdc_in_t beat);
      awaited_q.push_back(predict_civil_time(beat));
    endfunction

    function int outstanding();
      return awaited_q.size();
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("mismatch %s: expected %0d, actual %0d", name, want, got);
      end
    endfunction

    function void check_result(mjdc_out_t got);
      mjdc_out_t want;
      if (awaited_q.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected result: %p", got);
        return;
      end
      want = awaited_q.pop_front();
      compare_field("year", want.year, got.year);
      compare_field("month", want.month, got.month);
      compare_field("day", want.day, got.day);
      compare_field("day_of_year", want.day_of_year, got.day_of_year);
      compare_field("hour", want.hour, got.hour);
      compare_field("minute", want.minute, got.minute);
      compare_field("second", want.second, got.second);
      compare_field("gps_week", want.gps_week, got.gps_week);
      compare_field("week_day", want.week_day, got.week_day);
      compare_field("seconds_of_week", want.seconds_of_week, got.seconds_of_week);
      compare_field("input_valid", want.input_valid, got.input_valid);
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  mjdc_in_t  in_data;
  logic      out_valid;
  mjdc_out_t out_data;

  conversion_board board;
  int        idle_cycles = 0;

  mjd_to_civil_and_gps_time dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (rst_n && start && !busy) board.note_input(in_data);
    if (rst_n && out_valid) board.check_result(out_data);
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("tb_mjd_to_civil_and_gps_time: FAIL");
    $finish;
  end

  function automatic mjdc_in_t stamp(logic [16:0] mjd, logic [16:0] sod);
    mjdc_in_t s;
    s.day_number    = mjd;
    s.second_of_day = sod;
    return s;
  endfunction

  function automatic mjdc_in_t random_stamp();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 78)
      return stamp(17'($urandom_range(GPS_EPOCH_MJD, 131071)),
                   17'($urandom_range(0, SECONDS_PER_DAY - 1)));
    else if (pick < 88)
      return stamp(17'($urandom), 17'($urandom));
    else if (pick < 94)
      return stamp(17'($urandom_range(0, GPS_EPOCH_MJD - 1)),
                   17'($urandom_range(0, SECONDS_PER_DAY - 1)));
    else
      return stamp(17'($urandom_range(GPS_EPOCH_MJD, 131071)),
                   17'($urandom_range(SECONDS_PER_DAY, 131071)));
  endfunction

  // hold the beat until it is taken
  task automatic send_stamp(mjdc_in_t s);
    start   <= 1'b1;
    in_data <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause(int n);
    start   <= 1'b0;
    in_data <= mjdc_in_t'($urandom);
    repeat (n) @(posedge clk);
  endtask

  initial begin
    mjdc_in_t directed[$];
    int sent;
    int burst;
    int k;
    board   = new();
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(stamp(GPS_EPOCH_MJD, 17'd0));
    directed.push_back(stamp(GPS_EPOCH_MJD - 17'd1, 17'd0));
    directed.push_back(stamp(17'd0, 17'd0));
    directed.push_back(stamp(17'd131071, 17'd86399));
    directed.push_back(stamp(17'd131071, 17'd131071));
    directed.push_back(stamp(GPS_EPOCH_MJD, SECONDS_PER_DAY - 17'd1));
    directed.push_back(stamp(GPS_EPOCH_MJD, SECONDS_PER_DAY));
    directed.push_back(stamp(17'd0, 17'd131071));
    directed.push_back(stamp(17'd44250, 17'd43199));
    directed.push_back(stamp(17'd44251, 17'd3600));
    directed.push_back(stamp(17'd51603, 17'd59));
    directed.push_back(stamp(17'd51604, 17'd60));
    directed.push_back(stamp(17'd51909, 17'd3599));
    directed.push_back(stamp(17'd51910, 17'd86340));
    directed.push_back(stamp(17'd88127, 17'd12345));
    directed.push_back(stamp(17'd88128, 17'd54321));
    directed.push_back(stamp(17'd65535, 17'd65535));
    directed.push_back(stamp(17'd65536, 17'd65536));
    directed.push_back(stamp(17'd109207, 17'd1));
    directed.push_back(stamp(17'd131070, 17'd86400));

    foreach (directed[i]) begin
      send_stamp(directed[i]);
      if (i % 5 == 4) pause($urandom_range(1, 4));
    end

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_stamp(random_stamp());
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, 12));
    end
    start <= 1'b0;

    while (board.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb_mjd_to_civil_and_gps_time: PASS");
    end else begin
      $display("tb_mjd_to_civil_and_gps_time: FAIL");
    end
    $finish;
  end

endmodule
